### rtl/psa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg: shared types and codes for the page span allocator
// Request/response payloads, status codes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package psa_pkg;

	localparam int COUNT_W = 13;
	localparam int ADDR_W  = 12;
	localparam int STAMP_W = 16;

	typedef struct packed {
		logic              kind;
		logic [COUNT_W-1:0] page_count;
		logic [ADDR_W-1:0]  page_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start_page;
		logic [1:0]        status;
	} rsp_t;

	localparam logic KIND_ALLOC = 1'b0;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_UNKNOWN   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_SCAN,
		S_A_DEC,
		S_A_SPLIT,
		S_F_FIND,
		S_F_CHK,
		S_F_PREV,
		S_F_NEXT,
		S_F_COMMIT,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		SCAN_ALLOC,
		SCAN_FIND,
		SCAN_PREV,
		SCAN_NEXT
	} scan_mode_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TAKE,
		OP_SPLIT_NEW,
		OP_SPLIT_OLD,
		OP_BUMP,
		OP_SET_CUR,
		OP_MERGE_PREV,
		OP_MERGE_NEXT,
		OP_COMMIT
	} dp_op_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_HIT,
		RES_BUMP
	} res_src_t;

	typedef struct packed {
		logic       load_req;
		logic       scan_start;
		scan_mode_t scan_mode;
		dp_op_t     op;
		logic       res_load;
		status_t    res_status;
		res_src_t   res_src;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic hit;
		logic hit_free;
		logic split;
		logic empty;
		logic bump_fail;
	} dp_stat_t;

endpackage

### rtl/page_span_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_span_allocator: best-fit page span allocator with coalescing
// Allocates and frees page spans from a table, falling back to a bump
// pointer bounded by the pool_pages register.
//
//  channel | signals                    | payload
//  --------+----------------------------+-----------------------------
//  req     | req_valid / req_ready      | kind, page_count, page_addr
//  rsp     | rsp_valid / rsp_ready      | start_page, status
//  cfg     | cfg_we                     | cfg_wdata (pool_pages)
//
// Allocate runs one table scan, one entry per cycle through the single
// memory read port, and passes through S_A_SPLIT when a span is split.
// Free runs the lookup, predecessor and successor scans, or the lookup
// scan alone when the address is unknown or already free.
// One request is in flight at a time; a new request is accepted while the
// previous response still waits in the output register. A stalled response
// holds the controller in its last state until the output register drains.
// Reset clears all table entries through their valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module page_span_allocator #(
	parameter int POOL_PAGES_MAX = 4096,
	parameter int TABLE_ENTRIES  = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  psa_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output psa_pkg::rsp_t               rsp,
	input  logic                        cfg_we,
	input  logic [psa_pkg::COUNT_W-1:0] cfg_wdata
);
	import psa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	psa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_kind  (req.kind),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	psa_dp #(
		.POOL_PAGES_MAX (POOL_PAGES_MAX),
		.TABLE_ENTRIES  (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_in    (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_out   (rsp)
	);

endmodule

### rtl/psa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ctrl: request sequencer
// Walks each request through its table scans and updates, and owns the
// handshakes on both channels.
// ----------------------------------------------------------------------------
module psa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_kind,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  psa_pkg::dp_stat_t  stat,
	output psa_pkg::dp_cmd_t   cmd
);
	import psa_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid)
					state_d = (req_kind == KIND_ALLOC) ? S_A_SCAN : S_F_FIND;
			end
			S_A_SCAN: begin
				if (stat.scan_done)
					state_d = S_A_DEC;
			end
			S_A_DEC: begin
				if (stat.hit && stat.split && stat.empty)
					state_d = S_A_SPLIT;
				else
					state_d = S_RESP;
			end
			S_A_SPLIT: state_d = S_RESP;
			S_F_FIND: begin
				if (stat.scan_done)
					state_d = S_F_CHK;
			end
			S_F_CHK: begin
				if (!stat.hit || stat.hit_free)
					state_d = S_RESP;
				else
					state_d = S_F_PREV;
			end
			S_F_PREV: begin
				if (stat.scan_done)
					state_d = S_F_NEXT;
			end
			S_F_NEXT: begin
				if (stat.scan_done)
					state_d = S_F_COMMIT;
			end
			S_F_COMMIT: state_d = S_RESP;
			S_RESP: begin
				if (!out_valid_q || rsp_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.scan_mode  = SCAN_ALLOC;
		cmd.op         = OP_NONE;
		cmd.res_status = ST_OK;
		cmd.res_src    = RES_ZERO;
		req_ready      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req   = 1'b1;
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = (req_kind == KIND_ALLOC) ? SCAN_ALLOC : SCAN_FIND;
				end
			end
			S_A_DEC: begin
				cmd.res_load = 1'b1;
				if (stat.hit) begin
					if (!stat.split) begin
						cmd.op      = OP_TAKE;
						cmd.res_src = RES_HIT;
					end else if (stat.empty) begin
						cmd.op       = OP_SPLIT_NEW;
						cmd.res_load = 1'b0;
					end else begin
						cmd.res_status = ST_FULL;
					end
				end else if (stat.bump_fail) begin
					cmd.res_status = ST_EXHAUSTED;
				end else if (!stat.empty) begin
					cmd.res_status = ST_FULL;
				end else begin
					cmd.op      = OP_BUMP;
					cmd.res_src = RES_BUMP;
				end
			end
			S_A_SPLIT: begin
				cmd.op       = OP_SPLIT_OLD;
				cmd.res_load = 1'b1;
				cmd.res_src  = RES_HIT;
			end
			S_F_CHK: begin
				if (!stat.hit || stat.hit_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_UNKNOWN;
				end else begin
					cmd.op         = OP_SET_CUR;
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SCAN_PREV;
				end
			end
			S_F_PREV: begin
				if (stat.scan_done) begin
					cmd.op         = OP_MERGE_PREV;
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SCAN_NEXT;
				end
			end
			S_F_NEXT: begin
				if (stat.scan_done)
					cmd.op = OP_MERGE_NEXT;
			end
			S_F_COMMIT: begin
				cmd.op       = OP_COMMIT;
				cmd.res_load = 1'b1;
			end
			S_RESP: begin
				if (!out_valid_q || rsp_ready)
					cmd.out_load = 1'b1;
			end
			S_A_SCAN, S_F_FIND: ;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp_valid)
		else $error("result load did not raise valid");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready && state_q == S_RESP) |=> !$past(cmd.out_load))
		else $error("pending result overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |-> cmd.scan_start)
		else $error("request latched without a scan");

endmodule

### rtl/psa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_dp: span table datapath
// Span table memory with valid/free flags, one-entry-per-cycle scan engine,
// bump pointer, free stamp and the result register.
// ----------------------------------------------------------------------------
module psa_dp #(
	parameter int POOL_PAGES_MAX = 4096,
	parameter int TABLE_ENTRIES  = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psa_pkg::req_t                 req_in,
	input  logic                          cfg_we,
	input  logic [psa_pkg::COUNT_W-1:0]   cfg_wdata,
	input  psa_pkg::dp_cmd_t              cmd,
	output psa_pkg::dp_stat_t             stat,
	output psa_pkg::rsp_t                 rsp_out
);
	import psa_pkg::*;

	localparam int CW   = $clog2(POOL_PAGES_MAX + 1);
	localparam int LW   = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int XW   = ((CW > ADDR_W) ? CW : ADDR_W) + 1;
	localparam int IW   = $clog2(TABLE_ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
	localparam logic [COUNT_W-1:0] POOL_RESET = COUNT_W'(4096);

	typedef struct packed {
		logic [CW-1:0]      start;
		logic [CW-1:0]      pages;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	entry_t mem [TABLE_ENTRIES];
	entry_t rd_s1;
	logic [TABLE_ENTRIES-1:0] valid_q, free_q;

	logic [LW-1:0]      req_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COUNT_W-1:0] pool_q;
	logic [CW-1:0]      bump_q;
	logic [STAMP_W-1:0] stamp_q;

	logic       scan_busy_q, ev_v_s1, ev_last_s1, scan_done_q;
	scan_mode_t mode_q;
	logic [IW-1:0] ptr_q, ev_idx_s1;

	logic               hit_q, hit_free_q, emp_q;
	logic [IW-1:0]      hit_idx_q, emp_idx_q, cur_idx_q;
	logic [CW-1:0]      hit_start_q, hit_pages_q, cur_start_q, cur_pages_q;
	logic [STAMP_W-1:0] hit_stamp_q;

	logic [ADDR_W-1:0] res_start_q;
	status_t           res_status_q;
	rsp_t              out_q;

	// scan evaluation
	logic               ev_vld, ev_free, not_cur, fits, match;
	logic [CW:0]        ev_end, cur_end;
	logic [STAMP_W-1:0] ev_age, hit_age;
	logic [LW-1:0]      limit;

	always_comb begin
		ev_vld  = valid_q[ev_idx_s1];
		ev_free = free_q[ev_idx_s1];
		not_cur = ev_idx_s1 != cur_idx_q;
		ev_end  = {1'b0, rd_s1.start} + {1'b0, rd_s1.pages};
		cur_end = {1'b0, cur_start_q} + {1'b0, cur_pages_q};
		ev_age  = stamp_q - rd_s1.stamp;
		hit_age = stamp_q - hit_stamp_q;
		fits    = LW'(rd_s1.pages) >= req_q;
		case (mode_q)
			SCAN_ALLOC: match = ev_vld && ev_free && fits &&
				(!hit_q || rd_s1.pages < hit_pages_q ||
				 (rd_s1.pages == hit_pages_q && ev_age < hit_age));
			SCAN_FIND:  match = ev_vld && !hit_q && XW'(rd_s1.start) == XW'(addr_q);
			SCAN_PREV:  match = ev_vld && ev_free && not_cur && !hit_q &&
				XW'(ev_end) == XW'(addr_q);
			SCAN_NEXT:  match = ev_vld && ev_free && not_cur && !hit_q &&
				{1'b0, rd_s1.start} == cur_end;
			default:    match = 1'b0;
		endcase
	end

	assign limit = (LW'(pool_q) > LW'(POOL_PAGES_MAX)) ? LW'(POOL_PAGES_MAX) : LW'(pool_q);

	assign stat.scan_done = scan_done_q;
	assign stat.hit       = hit_q;
	assign stat.hit_free  = hit_free_q;
	assign stat.split     = LW'(hit_pages_q) > req_q;
	assign stat.empty     = emp_q;
	assign stat.bump_fail = ((LW+1)'(bump_q) + (LW+1)'(req_q)) > (LW+1)'(limit);

	assign rsp_out = out_q;

	// memory write port
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	entry_t        mem_wd;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = hit_idx_q;
		mem_wd = '{start: hit_start_q, pages: CW'(req_q), stamp: hit_stamp_q};
		case (cmd.op)
			OP_SPLIT_NEW: begin
				mem_we = 1'b1;
				mem_wa = emp_idx_q;
				mem_wd = '{start: hit_start_q + CW'(req_q),
					pages: hit_pages_q - CW'(req_q), stamp: stamp_q};
			end
			OP_SPLIT_OLD: mem_we = 1'b1;
			OP_BUMP: begin
				mem_we = 1'b1;
				mem_wa = emp_idx_q;
				mem_wd = '{start: bump_q, pages: CW'(req_q), stamp: '0};
			end
			OP_COMMIT: begin
				mem_we = 1'b1;
				mem_wa = cur_idx_q;
				mem_wd = '{start: cur_start_q, pages: cur_pages_q, stamp: stamp_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[ptr_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			free_q      <= '0;
			pool_q      <= POOL_RESET;
			bump_q      <= '0;
			stamp_q     <= '0;
			scan_busy_q <= 1'b0;
			ev_v_s1     <= 1'b0;
			ev_last_s1  <= 1'b0;
			scan_done_q <= 1'b0;
			hit_q       <= 1'b0;
			emp_q       <= 1'b0;
			ptr_q       <= '0;
			mode_q      <= SCAN_ALLOC;
		end else begin
			if (cfg_we)
				pool_q <= cfg_wdata;

			ev_v_s1     <= scan_busy_q;
			ev_last_s1  <= scan_busy_q && ptr_q == LAST_IDX;
			scan_done_q <= ev_v_s1 && ev_last_s1;
			if (cmd.scan_start) begin
				scan_busy_q <= 1'b1;
				ptr_q       <= '0;
				mode_q      <= cmd.scan_mode;
				hit_q       <= 1'b0;
				emp_q       <= 1'b0;
			end else if (scan_busy_q) begin
				ptr_q <= ptr_q + 1'b1;
				if (ptr_q == LAST_IDX)
					scan_busy_q <= 1'b0;
			end
			if (ev_v_s1 && match)
				hit_q <= 1'b1;
			if (ev_v_s1 && !ev_vld && !emp_q)
				emp_q <= 1'b1;

			case (cmd.op)
				OP_TAKE, OP_SPLIT_OLD: free_q[hit_idx_q] <= 1'b0;
				OP_SPLIT_NEW: begin
					valid_q[emp_idx_q] <= 1'b1;
					free_q[emp_idx_q]  <= 1'b1;
					stamp_q            <= stamp_q + 1'b1;
				end
				OP_BUMP: begin
					valid_q[emp_idx_q] <= 1'b1;
					free_q[emp_idx_q]  <= 1'b0;
					bump_q             <= bump_q + CW'(req_q);
				end
				OP_MERGE_PREV: begin
					if (hit_q)
						valid_q[cur_idx_q] <= 1'b0;
				end
				OP_MERGE_NEXT: begin
					if (hit_q)
						valid_q[hit_idx_q] <= 1'b0;
				end
				OP_COMMIT: begin
					free_q[cur_idx_q] <= 1'b1;
					stamp_q           <= stamp_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ev_idx_s1 <= ptr_q;
		if (cmd.load_req) begin
			req_q  <= (req_in.page_count == '0) ? LW'(1) : LW'(req_in.page_count);
			addr_q <= req_in.page_addr;
		end
		if (ev_v_s1 && match) begin
			hit_idx_q   <= ev_idx_s1;
			hit_start_q <= rd_s1.start;
			hit_pages_q <= rd_s1.pages;
			hit_stamp_q <= rd_s1.stamp;
			hit_free_q  <= ev_free;
		end
		if (ev_v_s1 && !ev_vld && !emp_q)
			emp_idx_q <= ev_idx_s1;

		case (cmd.op)
			OP_SET_CUR: begin
				cur_idx_q   <= hit_idx_q;
				cur_start_q <= hit_start_q;
				cur_pages_q <= hit_pages_q;
			end
			OP_MERGE_PREV: begin
				if (hit_q) begin
					cur_idx_q   <= hit_idx_q;
					cur_start_q <= hit_start_q;
					cur_pages_q <= hit_pages_q + cur_pages_q;
				end
			end
			OP_MERGE_NEXT: begin
				if (hit_q)
					cur_pages_q <= cur_pages_q + hit_pages_q;
			end
			default: ;
		endcase

		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_src)
				RES_HIT:  res_start_q <= ADDR_W'(hit_start_q);
				RES_BUMP: res_start_q <= ADDR_W'(bump_q);
				default:  res_start_q <= '0;
			endcase
		end
		if (cmd.out_load)
			out_q <= '{start_page: res_start_q, status: res_status_q};
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> !scan_busy_q)
		else $error("scan restarted while running");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !scan_busy_q && !ev_v_s1)
		else $error("table written during a scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= CW'(POOL_PAGES_MAX))
		else $error("bump pointer beyond pool");

	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(stamp_q) |-> ($past(cmd.op) == OP_SPLIT_NEW || $past(cmd.op) == OP_COMMIT))
		else $error("free stamp moved without a free entry");

endmodule
